// ===== rtl/etp_pkg.sv =====
// Package for the EEPROM transfer planner: default sizes, request codes,
// and the command/status structs between controller and datapath.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package etp_pkg;

  // Default geometry of the attached memory and the request bound.
  localparam int unsigned MemBytesDef   = 65536;
  localparam int unsigned PageBytesDef  = 64;
  localparam int unsigned MaxRequestDef = 2048;

  // Fixed field widths.
  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned OffsetW  = 17;
  localparam int unsigned CountW   = 12;
  localparam int unsigned AddrW    = 16;

  // Request type codes.
  localparam logic [ReqTypeW-1:0] ReqSeekSet = 3'd0;
  localparam logic [ReqTypeW-1:0] ReqSeekCur = 3'd1;
  localparam logic [ReqTypeW-1:0] ReqSeekEnd = 3'd2;
  localparam logic [ReqTypeW-1:0] ReqWrite   = 3'd3;
  localparam logic [ReqTypeW-1:0] ReqRead    = 3'd4;

  // Result status codes.
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusFault = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture the request fields
    logic plan;      // evaluate the request and update the position
    logic step;      // present one result and advance to the next chunk
  } etp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // the result presented now is the final one
  } etp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/etp_ctrl.sv =====
// Controller of the EEPROM transfer planner: sequences accept, plan and
// the emission of results. Depends on etp_pkg.
`default_nettype none

module etp_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output etp_pkg::etp_cmd_t cmd_o,
  input  etp_pkg::etp_sts_t sts_i
);
  import etp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPlan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // A new item may enter while the final result of the previous one is shown.
  assign busy_o         = !((state_q == StIdle) || ((state_q == StEmit) && sts_i.last));
  assign accept         = start_i && !busy_o;
  assign result_valid_o = (state_q == StEmit);

  assign cmd_o.load_req = accept;
  assign cmd_o.plan     = (state_q == StPlan);
  assign cmd_o.step     = (state_q == StEmit);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StPlan;
      end
      StPlan: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.last) begin
          state_d = accept ? StPlan : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_then_plan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> cmd_o.plan)
    else $error("accepted item was not planned in the next cycle");

  a_plan_then_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.plan |=> (result_valid_o && busy_o == !sts_i.last))
    else $error("planning was not followed by a result");

  a_emit_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && !sts_i.last) |=> cmd_o.step)
    else $error("results of one item stopped before the last one");
`endif

endmodule

`default_nettype wire

// ===== rtl/etp_dp.sv =====
// Datapath of the EEPROM transfer planner: request registers, position,
// page split register, seek and clamp arithmetic and the chunk walker.
// Depends on etp_pkg.
`default_nettype none

module etp_dp #(
  parameter int unsigned MEM_BYTES   = etp_pkg::MemBytesDef,
  parameter int unsigned PAGE_BYTES  = etp_pkg::PageBytesDef,
  parameter int unsigned MAX_REQUEST = etp_pkg::MaxRequestDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  etp_pkg::etp_cmd_t                  cmd_i,
  output etp_pkg::etp_sts_t                  sts_o,
  input  wire                                cfg_we_i,
  input  wire                                cfg_wdata_i,
  input  wire  [etp_pkg::ReqTypeW-1:0]       req_type_i,
  input  wire  signed [etp_pkg::OffsetW-1:0] offset_i,
  input  wire  [etp_pkg::CountW-1:0]         count_i,
  output logic                               status_o,
  output logic [etp_pkg::CountW-1:0]         granted_count_o,
  output logic [etp_pkg::AddrW-1:0]          chunk_address_o,
  output logic [etp_pkg::CountW-1:0]         chunk_length_o,
  output logic                               chunk_is_write_o,
  output logic [etp_pkg::AddrW-1:0]          new_position_o,
  output logic                               last_o
);
  import etp_pkg::*;

  localparam int unsigned TgtW  = OffsetW + 1;
  localparam int unsigned PageW = $clog2(PAGE_BYTES);
  localparam logic [AddrW-1:0]        MemLast = AddrW'(MEM_BYTES - 1);
  localparam logic signed [TgtW-1:0]  MemSz   = TgtW'(MEM_BYTES);
  localparam logic [AddrW:0]          MemSum  = (AddrW+1)'(MEM_BYTES);
  localparam logic [CountW-1:0]       MaxReq  = CountW'(MAX_REQUEST);
  localparam logic [PageW:0]          PageSz  = (PageW+1)'(PAGE_BYTES);

  // Request registers.
  logic [ReqTypeW-1:0]       req_type_q;
  logic signed [OffsetW-1:0] offset_q;
  logic [CountW-1:0]         count_q;

  // Control state.
  logic             split_en_q;
  logic [AddrW-1:0] position_q, position_d;

  // Result registers.
  logic              status_q, status_d;
  logic [CountW-1:0] granted_q, granted_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [CountW-1:0] left_q, left_d;
  logic              wr_q, wr_d;
  logic              split_q, split_d;
  logic              rw_q, rw_d;

  // Plan arithmetic.
  logic signed [TgtW-1:0] target;
  logic                   target_ok;
  logic [AddrW:0]         end_sum;
  logic [CountW-1:0]      grant;

  // Chunk walker.
  logic [PageW:0]    room;
  logic [CountW-1:0] len;

  always_comb begin
    unique case (req_type_q)
      ReqSeekCur: target = TgtW'(signed'({1'b0, position_q})) + TgtW'(offset_q);
      ReqSeekEnd: target = TgtW'(signed'({1'b0, MemLast})) + TgtW'(offset_q);
      default:    target = TgtW'(offset_q);
    endcase
    target_ok = (target >= 0) && (target < MemSz);
    // A seek from the end only reaches the range for offsets in -(MEM-1)..0,
    // which is exactly what the range check of the sum accepts.

    end_sum = {1'b0, position_q} + (AddrW+1)'(count_q);
    if (end_sum >= MemSum) grant = CountW'(MemLast - position_q);
    else                   grant = count_q;
  end

  always_comb begin
    status_d   = StatusFault;
    granted_d  = '0;
    addr_d     = '0;
    left_d     = '0;
    wr_d       = 1'b0;
    split_d    = 1'b0;
    rw_d       = 1'b0;
    position_d = position_q;
    if ((req_type_q == ReqSeekSet) || (req_type_q == ReqSeekCur) ||
        (req_type_q == ReqSeekEnd)) begin
      if (target_ok) begin
        status_d   = StatusOk;
        position_d = target[AddrW-1:0];
      end
    end else if (((req_type_q == ReqWrite) || (req_type_q == ReqRead)) &&
                 (count_q <= MaxReq)) begin
      status_d   = StatusOk;
      rw_d       = 1'b1;
      wr_d       = (req_type_q == ReqWrite);
      split_d    = (req_type_q == ReqWrite) && split_en_q;
      granted_d  = grant;
      addr_d     = position_q;
      left_d     = grant;
      position_d = position_q + AddrW'(grant);
    end
  end

  // Only the first chunk of a split write can start inside a page.
  assign room = PageSz - {1'b0, addr_q[PageW-1:0]};
  assign len  = (split_q && (left_q > CountW'(room))) ? CountW'(room) : left_q;
  assign sts_o.last = (left_q == len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      split_en_q <= 1'b1;
    end else begin
      if (cfg_we_i) split_en_q <= cfg_wdata_i;
      if (cmd_i.plan) position_q <= position_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      offset_q   <= offset_i;
      count_q    <= count_i;
    end
    if (cmd_i.plan) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      addr_q    <= addr_d;
      left_q    <= left_d;
      wr_q      <= wr_d;
      split_q   <= split_d;
      rw_q      <= rw_d;
    end else if (cmd_i.step) begin
      addr_q <= addr_q + AddrW'(len);
      left_q <= left_q - len;
    end
  end

  assign status_o         = status_q;
  assign granted_count_o  = granted_q;
  assign chunk_address_o  = addr_q;
  assign chunk_length_o   = len;
  assign chunk_is_write_o = wr_q;
  assign new_position_o   = position_q;
  assign last_o           = sts_o.last;

`ifndef SYNTHESIS
  a_fault_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && status_q == StatusFault) |-> (len == '0 && sts_o.last))
    else $error("fault result carried a chunk or was not final");

  a_chunks_adjacent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !sts_o.last) |=> (addr_q == $past(addr_q + AddrW'(len))))
    else $error("next chunk does not start where the previous one ended");

  a_end_matches_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && sts_o.last && rw_q) |-> (addr_q + AddrW'(len) == position_q))
    else $error("final chunk does not end at the new position");
`endif

endmodule

`default_nettype wire

// ===== rtl/eeprom_transfer_planner_core.sv =====
// Top level of the EEPROM transfer planner: controller plus datapath.
// Depends on etp_pkg, etp_ctrl and etp_dp.
`default_nettype none

// Usage.
// The block keeps a byte position into a serial EEPROM and plans transfers.
// An item (req_type_i, offset_i, count_i) is taken at a rising edge where
// start_i is high and busy_o is low. Seek items move the position; read and
// write items clamp their count at the end of memory, advance the position
// and emit transfer chunks. Writes are split at page boundaries while the
// page split register is set. Unknown types, seeks outside the memory and
// counts above MAX_REQUEST return one result with fault status.
// Each result is shown for exactly one cycle with result_valid_o high;
// last_o marks the final result of an item. The receiver cannot stall, so
// results are never held back.
// Timing: an accepted item passes through the planning state (seek range
// check or count clamp) and then through the emit state, which shows its
// results. Once an item is accepted, the block takes the next one only at
// the edge that ends its final result. A split write yields up to
// MAX_REQUEST/PAGE_BYTES + 1 results; seeks, reads, unsplit writes and
// faults yield one. The single chunk walker emits one chunk per cycle.
// Reset clears the position to zero and sets page splitting on. The page
// split register is written by cfg_we_i/cfg_wdata_i; the user must write it
// only while the block is idle, which the block itself does not enforce.
// PAGE_BYTES must be a power of two.

module eeprom_transfer_planner_core #(
  parameter int unsigned MEM_BYTES   = etp_pkg::MemBytesDef,
  parameter int unsigned PAGE_BYTES  = etp_pkg::PageBytesDef,
  parameter int unsigned MAX_REQUEST = etp_pkg::MaxRequestDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  output logic                               busy_o,
  input  wire                                cfg_we_i,
  input  wire                                cfg_wdata_i,
  input  wire  [etp_pkg::ReqTypeW-1:0]       req_type_i,
  input  wire  signed [etp_pkg::OffsetW-1:0] offset_i,
  input  wire  [etp_pkg::CountW-1:0]         count_i,
  output logic                               result_valid_o,
  output logic                               status_o,
  output logic [etp_pkg::CountW-1:0]         granted_count_o,
  output logic [etp_pkg::AddrW-1:0]          chunk_address_o,
  output logic [etp_pkg::CountW-1:0]         chunk_length_o,
  output logic                               chunk_is_write_o,
  output logic [etp_pkg::AddrW-1:0]          new_position_o,
  output logic                               last_o
);
  import etp_pkg::*;

  etp_cmd_t cmd;
  etp_sts_t sts;

  // The controller decides when to capture, plan and step; it never looks
  // at the payload.
  etp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  // The datapath holds the position, evaluates the request and walks the
  // chunks of a split write one page at a time.
  etp_dp #(
    .MEM_BYTES   (MEM_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_REQUEST (MAX_REQUEST)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .offset_i         (offset_i),
    .count_i          (count_i),
    .status_o         (status_o),
    .granted_count_o  (granted_count_o),
    .chunk_address_o  (chunk_address_o),
    .chunk_length_o   (chunk_length_o),
    .chunk_is_write_o (chunk_is_write_o),
    .new_position_o   (new_position_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
